FILE: hw/rtl/msst_pkg.sv
// Shared types and constants for the match slot scheduler timer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package msst_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PRESCALE_W = 8;
    localparam int unsigned FIRED_W = 4;
    localparam int unsigned SLOT_FIELD_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd24;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_PRESCALE = 1'b0;

    // Request opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] delay;
        logic              repeat_req;
    } in_t;

    typedef struct packed {
        logic [FIRED_W-1:0]      fired;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    accepted;
        logic                    full_res;
        logic [TIME_W-1:0]       now;
    } out_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

FILE: hw/rtl/msst_cfg.sv
// APB register file of the match slot scheduler timer: holds the prescale register.
// Depends on msst_pkg.
`timescale 1ns / 1ps

module msst_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msst_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [msst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [msst_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [msst_pkg::PRESCALE_W-1:0]     prescale
);

    logic [msst_pkg::PRESCALE_W-1:0] prescale_reg;
    logic [msst_pkg::PRESCALE_W-1:0] prescale_next;
    logic                            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        prescale_next = prescale_reg;
        if (wr_en && (paddr[2] == msst_pkg::REG_PRESCALE))
        begin
            prescale_next = pwdata[msst_pkg::PRESCALE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= msst_pkg::PRESCALE_RESET;
        end
        else
        begin
            prescale_reg <= prescale_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == msst_pkg::REG_PRESCALE)
        begin
            prdata = {{(msst_pkg::APB_DATA_W - msst_pkg::PRESCALE_W){1'b0}}, prescale_reg};
        end
    end

    assign prescale = prescale_reg;

endmodule

FILE: hw/rtl/msst_ctrl.sv
// Controller of the match slot scheduler timer: sequences each request
// through a capture cycle and an execute cycle. Depends on msst_pkg.
`timescale 1ns / 1ps

module msst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output msst_pkg::cmd_t cmd
);

    msst_pkg::state_t state_reg;
    msst_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msst_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            msst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = msst_pkg::ST_EXEC;
                end
            end
            msst_pkg::ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = msst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = msst_pkg::ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

FILE: hw/rtl/msst_dp.sv
// Datapath of the match slot scheduler timer: prescaler, time base, match
// slots and the result register. Depends on msst_pkg.
`timescale 1ns / 1ps

module msst_dp #(
    parameter int unsigned SLOTS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msst_pkg::cmd_t                  cmd,
    input  msst_pkg::in_t                   req,
    input  logic [msst_pkg::PRESCALE_W-1:0] prescale,
    output msst_pkg::out_t                  result
);

    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    msst_pkg::in_t                   req_reg;
    msst_pkg::out_t                  result_reg;
    msst_pkg::out_t                  result_next;
    logic [msst_pkg::PRESCALE_W-1:0] pcount_reg;
    logic [msst_pkg::PRESCALE_W-1:0] pcount_next;
    logic [msst_pkg::TIME_W-1:0]     time_reg;
    logic [msst_pkg::TIME_W-1:0]     time_next;
    logic [msst_pkg::TIME_W-1:0]     time_inc;
    logic [msst_pkg::TIME_W-1:0]     delay_eff;
    logic [msst_pkg::TIME_W-1:0]     match_reg [SLOTS];
    logic [msst_pkg::TIME_W-1:0]     match_next [SLOTS];
    logic [msst_pkg::TIME_W-1:0]     reload_reg [SLOTS];
    logic [msst_pkg::TIME_W-1:0]     reload_next [SLOTS];
    logic [SLOTS-1:0]                active_reg;
    logic [SLOTS-1:0]                active_next;
    logic [SLOTS-1:0]                hit;
    logic [CNT_W-1:0]                nslot_reg;
    logic [CNT_W-1:0]                nslot_next;
    logic                            wrap;
    logic                            has_free;

    assign wrap      = (pcount_reg >= prescale);
    assign time_inc  = time_reg + 1'b1;
    assign delay_eff = (req_reg.delay == '0) ? msst_pkg::TIME_W'(1) : req_reg.delay;
    assign has_free  = (nslot_reg < SLOTS_CNT);

    always_comb
    begin
        pcount_next = pcount_reg;
        time_next   = time_reg;
        active_next = active_reg;
        nslot_next  = nslot_reg;
        hit         = '0;
        result_next = result_reg;
        for (int k = 0; k < SLOTS; k++)
        begin
            match_next[k]  = match_reg[k];
            reload_next[k] = reload_reg[k];
        end

        if (cmd.exec)
        begin
            result_next = '0;
            if (req_reg.op == msst_pkg::OP_TICK)
            begin
                if (wrap)
                begin
                    pcount_next = '0;
                    time_next   = time_inc;
                    // Every slot is compared against the new time in parallel.
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        hit[k] = active_reg[k] && (match_reg[k] == time_inc);
                        if (hit[k])
                        begin
                            if (reload_reg[k] != '0)
                            begin
                                match_next[k] = time_inc + reload_reg[k];
                            end
                            else
                            begin
                                active_next[k] = 1'b0;
                            end
                        end
                    end
                end
                else
                begin
                    pcount_next = pcount_reg + 1'b1;
                end
                for (int i = 0; i < msst_pkg::FIRED_W; i++)
                begin
                    if (i < SLOTS)
                    begin
                        result_next.fired[i] = hit[i];
                    end
                end
            end
            else if (has_free)
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (nslot_reg[SLOT_W-1:0] == SLOT_W'(k))
                    begin
                        match_next[k]  = time_reg + delay_eff;
                        reload_next[k] = req_reg.repeat_req ? delay_eff : '0;
                        active_next[k] = 1'b1;
                    end
                end
                nslot_next           = nslot_reg + 1'b1;
                result_next.slot     = msst_pkg::SLOT_FIELD_W'(nslot_reg);
                result_next.accepted = 1'b1;
            end
            else
            begin
                result_next.full_res = 1'b1;
            end
            result_next.now = time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= '0;
            time_reg   <= '0;
            active_reg <= '0;
            nslot_reg  <= '0;
        end
        else
        begin
            pcount_reg <= pcount_next;
            time_reg   <= time_next;
            active_reg <= active_next;
            nslot_reg  <= nslot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        result_reg <= result_next;
        for (int k = 0; k < SLOTS; k++)
        begin
            match_reg[k]  <= match_next[k];
            reload_reg[k] <= reload_next[k];
        end
    end

    assign result = result_reg;

endmodule

FILE: hw/rtl/match_slot_scheduler_timer.sv
// Top level of the match slot scheduler timer: register port, controller and datapath.
// Depends on msst_pkg, msst_cfg, msst_ctrl and msst_dp.
`timescale 1ns / 1ps

// A request (a raw tick or a schedule) is taken when start is high and busy
// is low. The controller captures the request in its idle state and then
// updates the prescaler, time base and all match slots in parallel in its
// execute state, when busy is high and no new request is taken. The result
// appears with done for exactly one cycle, the cycle after the update, and
// must be taken then: there is no back pressure on the result side. Slots are
// claimed in order and never freed. The prescale register is written over APB
// and is meant to change only while no request is in flight.
module match_slot_scheduler_timer #(
    parameter int unsigned SLOTS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  msst_pkg::in_t                       req,
    output logic                                done,
    output msst_pkg::out_t                      result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msst_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [msst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [msst_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    msst_pkg::cmd_t                  cmd;
    logic [msst_pkg::PRESCALE_W-1:0] prescale;

    msst_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .prescale (prescale)
    );

    msst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    msst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .prescale (prescale),
        .result   (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_sched_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.accepted || result.full_res)) |-> (result.fired == '0))
        else $error("schedule result reports fired slots");

    a_accept_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.accepted && result.full_res))
        else $error("schedule result both accepted and refused");

endmodule

FILE: test/msst_checker.sv
`timescale 1ns / 1ps
// Result checker for the match slot scheduler timer: follows prescale writes, predicts
// each request's result and compares it with what the block returns.
// Depends on msst_pkg.

module msst_checker #(
    parameter int unsigned SLOTS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  msst_pkg::in_t                       req,
    input  logic                                done,
    input  msst_pkg::out_t                      result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msst_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [msst_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [msst_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    output int                                  errors,
    output int                                  pending,
    output int                                  checked,
    output int                                  fires,
    output int                                  refusals,
    output logic [msst_pkg::TIME_W-1:0]         time_now
);

    logic [msst_pkg::PRESCALE_W-1:0] prescale_q;
    logic [msst_pkg::PRESCALE_W-1:0] count_q;
    logic [msst_pkg::TIME_W-1:0]     now_q;
    logic [msst_pkg::TIME_W-1:0]     match_q [SLOTS];
    logic [msst_pkg::TIME_W-1:0]     reload_q [SLOTS];
    logic                            armed_q [SLOTS];
    int                              claimed;
    msst_pkg::out_t                  timer_results [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // One raw clock tick: the time base moves only when the prescaler wraps, and
    // only then are the slots compared against it.
    task automatic advance_timer(output logic [msst_pkg::FIRED_W-1:0] hits);
        hits = '0;
        if (count_q >= prescale_q)
        begin
            count_q = '0;
            now_q = now_q + 1'b1;
            for (int k = 0; k < SLOTS; k++)
            begin
                if (armed_q[k] && match_q[k] == now_q)
                begin
                    if (k < msst_pkg::FIRED_W)
                        hits[k] = 1'b1;
                    if (reload_q[k] != 0)
                        match_q[k] = now_q + reload_q[k];
                    else
                        armed_q[k] = 1'b0;
                end
            end
        end
        else
        begin
            count_q = count_q + 1'b1;
        end
    endtask

    task automatic predict_timer_result(input msst_pkg::in_t r, output msst_pkg::out_t o);
        logic [msst_pkg::TIME_W-1:0] d;
        o = '0;
        if (r.op == msst_pkg::OP_TICK)
        begin
            advance_timer(o.fired);
        end
        else if (claimed < SLOTS)
        begin
            d = (r.delay == 0) ? 1 : r.delay;
            match_q[claimed] = now_q + d;
            reload_q[claimed] = r.repeat_req ? d : '0;
            armed_q[claimed] = 1'b1;
            o.slot = msst_pkg::SLOT_FIELD_W'(claimed);
            o.accepted = 1'b1;
            claimed++;
        end
        else
        begin
            o.full_res = 1'b1;
        end
        o.now = now_q;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        msst_pkg::out_t want;
        if (!rst_n)
        begin
            prescale_q = msst_pkg::PRESCALE_RESET;
            count_q = '0;
            now_q = '0;
            claimed = 0;
            for (int k = 0; k < SLOTS; k++)
            begin
                match_q[k] = '0;
                reload_q[k] = '0;
                armed_q[k] = 1'b0;
            end
            timer_results.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pready
                && paddr[msst_pkg::APB_ADDR_W-1:2] == msst_pkg::REG_PRESCALE)
            begin
                if (pwrite)
                    prescale_q = pwdata[msst_pkg::PRESCALE_W-1:0];
                else if (prdata[msst_pkg::PRESCALE_W-1:0] !== prescale_q)
                    report("prescale read back", prdata, prescale_q);
            end
            // Results are handled before new requests so that a stray strobe can
            // never be matched against a request taken at the same edge.
            if (done)
            begin
                if (timer_results.size() == 0)
                begin
                    report("result with no request outstanding", result, 0);
                end
                else
                begin
                    want = timer_results.pop_front();
                    if (result.fired !== want.fired)
                        report("fired", result.fired, want.fired);
                    if (result.slot !== want.slot)
                        report("slot", result.slot, want.slot);
                    if (result.accepted !== want.accepted)
                        report("accepted", result.accepted, want.accepted);
                    if (result.full_res !== want.full_res)
                        report("full_res", result.full_res, want.full_res);
                    if (result.now !== want.now)
                        report("now", result.now, want.now);
                    checked++;
                    fires += $countones(want.fired);
                    refusals += want.full_res;
                    time_now = want.now;
                end
            end
            if (start && !busy)
            begin
                predict_timer_result(req, want);
                timer_results.push_back(want);
            end
            pending = timer_results.size();
        end
    end

    initial
    begin
        errors = 0;
        pending = 0;
        checked = 0;
        fires = 0;
        refusals = 0;
        time_now = '0;
    end

endmodule

FILE: test/match_slot_scheduler_timer_test.sv
`timescale 1ns / 1ps
// Top of the match slot scheduler timer testbench: clock, reset, register writes and
// request stimulus, with msst_checker doing the prediction. Depends on msst_pkg.

module match_slot_scheduler_timer_test;

    localparam int unsigned SLOTS = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [msst_pkg::APB_ADDR_W-1:0] ADDR_PRESCALE =
        {msst_pkg::REG_PRESCALE, 2'b00};
    localparam logic [msst_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
        {~msst_pkg::REG_PRESCALE, 2'b00};

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    msst_pkg::in_t                   req;
    logic                            done;
    msst_pkg::out_t                  result;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [msst_pkg::APB_ADDR_W-1:0] paddr;
    logic [msst_pkg::APB_DATA_W-1:0] pwdata;
    logic [msst_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int                              errors;
    int                              pending;
    int                              checked;
    int                              fires;
    int                              refusals;
    logic [msst_pkg::TIME_W-1:0]     time_now;
    int                              cycles;
    int                              settings;

    match_slot_scheduler_timer #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    msst_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .errors(errors),
        .pending(pending),
        .checked(checked),
        .fires(fires),
        .refusals(refusals),
        .time_now(time_now)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("match_slot_scheduler_timer test failed");
            $finish;
        end
    end

    // Holds the request until the block takes it; start stays high afterwards so
    // that back-to-back requests need no second assignment in the same step.
    task automatic issue(input logic op, input logic [msst_pkg::TIME_W-1:0] delay,
                         input logic rep);
        start <= 1'b1;
        req <= '{op: op, delay: delay, repeat_req: rep};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Waits until every request has come back, then adds an idle margin.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [msst_pkg::APB_ADDR_W-1:0] a,
                              input logic [msst_pkg::APB_DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_prescale(input logic [msst_pkg::APB_DATA_W-1:0] v);
        drain();
        reg_access(1'b1, ADDR_PRESCALE, v);
        reg_access(1'b0, ADDR_PRESCALE, '0);
        settings++;
    endtask

    task automatic run_phase(input logic [msst_pkg::PRESCALE_W-1:0] ps, input int items,
                             input int idle_pct);
        logic [msst_pkg::APB_DATA_W-1:0] v;
        logic [msst_pkg::TIME_W-1:0]     d;
        v = $urandom;
        v[msst_pkg::PRESCALE_W-1:0] = ps;
        set_prescale(v);
        for (int n = 0; n < items; n++)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            case ($urandom_range(3))
                0: d = $urandom_range(3);
                1: d = '1;
                default: d = $urandom;
            endcase
            issue(($urandom_range(9) == 0) ? msst_pkg::OP_SCHEDULE : msst_pkg::OP_TICK,
                  d, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        cycles = 0;
        settings = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fastest time base, so the first slots fire within a few ticks.
        set_prescale(32'd0);
        issue(msst_pkg::OP_SCHEDULE, 32'd0, 1'b1);
        issue(msst_pkg::OP_TICK, '1, 1'b1);
        issue(msst_pkg::OP_SCHEDULE, 32'd3, 1'b0);
        issue(msst_pkg::OP_SCHEDULE, 32'd2, 1'b1);
        repeat (4) issue(msst_pkg::OP_TICK, 32'd0, 1'b0);
        // The last slot's match wraps past the top of the time base.
        issue(msst_pkg::OP_SCHEDULE, '1, 1'b1);
        issue(msst_pkg::OP_SCHEDULE, 32'd0, 1'b0);
        issue(msst_pkg::OP_SCHEDULE, '1, 1'b1);
        issue(msst_pkg::OP_TICK, 32'd0, 1'b0);

        // Let the prescaler run up, then drop the prescale below its count.
        set_prescale(32'd255);
        repeat (10) issue(msst_pkg::OP_TICK, 32'd0, 1'b0);
        set_prescale(32'd3);
        repeat (2) issue(msst_pkg::OP_TICK, 32'd0, 1'b0);
        // Upper data bits are dropped and the unmapped address is ignored.
        set_prescale(32'hFFFF_FF05);
        reg_access(1'b1, ADDR_UNMAPPED, '1);
        reg_access(1'b0, ADDR_PRESCALE, '0);
        repeat (7) issue(msst_pkg::OP_TICK, 32'd0, 1'b0);

        run_phase(8'd0, 400, 0);
        run_phase(8'd1, 300, 50);
        run_phase(8'd255, 120, 0);
        run_phase(8'd24, 250, 28);
        run_phase(8'($urandom_range(2, 7)), 230, 50);

        drain();
        repeat (10) @(posedge clk);
        $display("Checked %0d results under %0d prescale settings.", checked, settings);
        $display("Saw %0d slot firings and %0d refused schedules; time base ended at %0d.",
                 fires, refusals, time_now);
        if (errors == 0)
            $display("match_slot_scheduler_timer test passed");
        else
            $display("match_slot_scheduler_timer test failed");
        $finish;
    end

endmodule
